// File: src/qfs_pkg.sv
// Shared types and constants for the quoted field splitter.
package qfs_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned DELIM_REGS  = 4;
   localparam int unsigned DELIM_CNT_W = 3;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 8;

   localparam logic [BYTE_W-1:0] QUOTE_BYTE = 8'd34;

   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_A     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_B     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_C     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIM_D     = 3'd4;

   localparam logic [DELIM_CNT_W-1:0] DELIM_COUNT_RESET = 3'd1;
   localparam logic [BYTE_W-1:0] DELIM_A_RESET = 8'd44;
   localparam logic [BYTE_W-1:0] DELIM_B_RESET = 8'd9;
   localparam logic [BYTE_W-1:0] DELIM_C_RESET = 8'd32;
   localparam logic [BYTE_W-1:0] DELIM_D_RESET = 8'd59;

   typedef enum logic [1:0] {
      MODE_START,
      MODE_UNQ,
      MODE_QUOTED,
      MODE_QSEEN
   } parse_mode_type;

   typedef enum logic [1:0] {
      EMIT_RUN,
      EMIT_BYTES,
      EMIT_FEND,
      EMIT_TAIL
   } emit_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_valid;
      logic              field_end;
      logic              string_end;
      logic              overflow;
      logic              run_last;
   } rsp_word_type;

endpackage

// File: src/qfs_req_if.sv
// Input channel: string bytes and terminators.
interface qfs_req_if;
   logic                       valid;
   logic                       ready;
   logic [qfs_pkg::BYTE_W-1:0] in_byte;
   logic                       is_terminator;

   modport source (output valid, output in_byte, output is_terminator, input ready);
   modport sink   (input valid, input in_byte, input is_terminator, output ready);
endinterface

// File: src/qfs_rsp_if.sv
// Result channel: field bytes and field end markers.
interface qfs_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [qfs_pkg::BYTE_W-1:0] out_byte;
   logic                       byte_valid;
   logic                       field_end;
   logic                       string_end;
   logic                       overflow;
   logic                       run_last;

   modport source (output valid, output out_byte, output byte_valid, output field_end,
                   output string_end, output overflow, output run_last, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input field_end,
                   input string_end, input overflow, input run_last, output ready);
endinterface

// File: src/qfs_store.sv
// Quoted content buffer: one write port, one registered read port.
module qfs_store #(
   parameter int unsigned DEPTH  = 32,
   parameter int unsigned DATA_W = 8,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/quoted_field_splitter_core.sv
// Top level of the quoted field splitter: parser, buffer control and result register.
// Result words are registered; quoted field bytes are emitted only once the field closes.
// Throughput: one input word per cycle while the result register can load; closing a
// quoted field stalls input while its bytes (one buffer read each), field end and tail go out.
// Reset: parse mode, emit state, buffer fill, overflow flag and result valid flag clear;
// delimiter registers return to their defaults; buffer contents and result word are kept.
module quoted_field_splitter_core #(
   parameter int unsigned QUOTED_DEPTH = 32,
   parameter int unsigned DELIM_SLOTS  = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   qfs_req_if.sink                         req_if,
   qfs_rsp_if.source                       rsp_if,
   input  logic                            csr_we,
   input  logic [qfs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [qfs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned ADDR_W     = (QUOTED_DEPTH > 1) ? $clog2(QUOTED_DEPTH) : 1;
   localparam int unsigned FILL_W     = $clog2(QUOTED_DEPTH + 1);
   localparam int unsigned USED_SLOTS =
      (DELIM_SLOTS < qfs_pkg::DELIM_REGS) ? DELIM_SLOTS : qfs_pkg::DELIM_REGS;

   qfs_pkg::parse_mode_type mode_ff, mode_in;
   qfs_pkg::emit_state_type state_ff, state_in;
   logic [FILL_W-1:0]              fill_ff, fill_in;
   logic                           ovf_ff, ovf_in;
   logic [ADDR_W-1:0]              idx_ff, idx_in;
   logic                           se_ff, se_in;
   logic                           tail_ff, tail_in;
   logic [qfs_pkg::BYTE_W-1:0]     tail_byte_ff, tail_byte_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   qfs_pkg::rsp_word_type          rsp_word_ff, rsp_word_in;

   logic [qfs_pkg::DELIM_CNT_W-1:0] delim_count_ff;
   logic [qfs_pkg::BYTE_W-1:0]      delim_ff [qfs_pkg::DELIM_REGS];

   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [qfs_pkg::BYTE_W-1:0] wr_data;
   logic                       rd_en;
   logic [ADDR_W-1:0]          rd_addr;
   logic [qfs_pkg::BYTE_W-1:0] rd_data;

   logic                       load_ok;
   logic                       accept;
   logic [qfs_pkg::BYTE_W-1:0] in_b;
   logic                       in_term;
   logic                       is_quote;
   logic                       is_delim;
   logic [FILL_W-1:0]          next_idx;

   function automatic qfs_pkg::rsp_word_type make_word(
      input logic [qfs_pkg::BYTE_W-1:0] b,
      input logic                       valid,
      input logic                       fe,
      input logic                       se,
      input logic                       ov,
      input logic                       last
   );
      qfs_pkg::rsp_word_type w;
      w.out_byte   = valid ? b : '0;
      w.byte_valid = valid;
      w.field_end  = fe;
      w.string_end = se;
      w.overflow   = ov;
      w.run_last   = last;
      return w;
   endfunction

   qfs_store #(
      .DEPTH  (QUOTED_DEPTH),
      .DATA_W (qfs_pkg::BYTE_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign load_ok      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == qfs_pkg::EMIT_RUN) && load_ok;
   assign accept       = req_if.valid && req_if.ready;
   assign in_b         = req_if.in_byte;
   assign in_term      = req_if.is_terminator;
   assign is_quote     = (in_b == qfs_pkg::QUOTE_BYTE);
   assign next_idx     = FILL_W'(idx_ff) + FILL_W'(1);

   always_comb begin
      is_delim = 1'b0;
      for (int i = 0; i < USED_SLOTS; i++) begin
         if ((qfs_pkg::DELIM_CNT_W'(i) < delim_count_ff) && (delim_ff[i] != '0) &&
             (delim_ff[i] == in_b)) begin
            is_delim = 1'b1;
         end
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      state_in     = state_ff;
      fill_in      = fill_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      se_in        = se_ff;
      tail_in      = tail_ff;
      tail_byte_in = tail_byte_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_word_in  = rsp_word_ff;
      wr_en        = 1'b0;
      wr_addr      = fill_ff[ADDR_W-1:0];
      wr_data      = in_b;
      rd_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         qfs_pkg::EMIT_RUN: begin
            if (accept) begin
               unique case (mode_ff)
                  qfs_pkg::MODE_START: begin
                     if (in_term) begin
                        rsp_valid_in = 1'b1;
                        rsp_word_in  = make_word('0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
                     end else if (is_quote) begin
                        fill_in = '0;
                        ovf_in  = 1'b0;
                        mode_in = qfs_pkg::MODE_QUOTED;
                     end else if (is_delim) begin
                        rsp_valid_in = 1'b1;
                        rsp_word_in  = make_word('0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_word_in  = make_word(in_b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
                        mode_in      = qfs_pkg::MODE_UNQ;
                     end
                  end
                  qfs_pkg::MODE_UNQ: begin
                     rsp_valid_in = 1'b1;
                     if (in_term) begin
                        rsp_word_in = make_word('0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
                        mode_in     = qfs_pkg::MODE_START;
                     end else if (is_delim) begin
                        rsp_word_in = make_word('0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
                        mode_in     = qfs_pkg::MODE_START;
                     end else begin
                        rsp_word_in = make_word(in_b, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
                     end
                  end
                  qfs_pkg::MODE_QUOTED: begin
                     if (in_term) begin
                        fill_in      = '0;
                        ovf_in       = 1'b0;
                        rsp_valid_in = 1'b1;
                        rsp_word_in  = make_word('0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1);
                        mode_in      = qfs_pkg::MODE_START;
                     end else if (is_quote) begin
                        mode_in = qfs_pkg::MODE_QSEEN;
                     end else if (fill_ff < FILL_W'(QUOTED_DEPTH)) begin
                        wr_en   = 1'b1;
                        fill_in = fill_ff + FILL_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  qfs_pkg::MODE_QSEEN: begin
                     if (!in_term && is_quote) begin
                        if (fill_ff < FILL_W'(QUOTED_DEPTH)) begin
                           wr_en   = 1'b1;
                           fill_in = fill_ff + FILL_W'(1);
                        end else begin
                           ovf_in = 1'b1;
                        end
                        mode_in = qfs_pkg::MODE_QUOTED;
                     end else begin
                        se_in        = in_term;
                        tail_in      = !in_term && !is_delim;
                        tail_byte_in = in_b;
                        idx_in       = '0;
                        rd_en        = 1'b1;
                        mode_in      = tail_in ? qfs_pkg::MODE_UNQ : qfs_pkg::MODE_START;
                        state_in     = (fill_ff == '0) ? qfs_pkg::EMIT_FEND
                                                       : qfs_pkg::EMIT_BYTES;
                     end
                  end
                  default: begin
                     mode_in = qfs_pkg::MODE_START;
                  end
               endcase
            end
         end
         qfs_pkg::EMIT_BYTES: begin
            if (load_ok) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = make_word(rd_data, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
               if (next_idx == fill_ff) begin
                  state_in = qfs_pkg::EMIT_FEND;
               end else begin
                  idx_in  = next_idx[ADDR_W-1:0];
                  rd_en   = 1'b1;
                  rd_addr = next_idx[ADDR_W-1:0];
               end
            end
         end
         qfs_pkg::EMIT_FEND: begin
            if (load_ok) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = make_word('0, 1'b0, 1'b1, se_ff, ovf_ff, !tail_ff);
               fill_in      = '0;
               ovf_in       = 1'b0;
               state_in     = tail_ff ? qfs_pkg::EMIT_TAIL : qfs_pkg::EMIT_RUN;
            end
         end
         qfs_pkg::EMIT_TAIL: begin
            if (load_ok) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = make_word(tail_byte_ff, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
               state_in     = qfs_pkg::EMIT_RUN;
            end
         end
         default: begin
            state_in = qfs_pkg::EMIT_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= qfs_pkg::MODE_START;
         state_ff       <= qfs_pkg::EMIT_RUN;
         fill_ff        <= '0;
         ovf_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         delim_count_ff <= qfs_pkg::DELIM_COUNT_RESET;
         delim_ff[0]    <= qfs_pkg::DELIM_A_RESET;
         delim_ff[1]    <= qfs_pkg::DELIM_B_RESET;
         delim_ff[2]    <= qfs_pkg::DELIM_C_RESET;
         delim_ff[3]    <= qfs_pkg::DELIM_D_RESET;
      end else begin
         mode_ff      <= mode_in;
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               qfs_pkg::CSR_DELIM_COUNT: delim_count_ff <= csr_wdata[qfs_pkg::DELIM_CNT_W-1:0];
               qfs_pkg::CSR_DELIM_A:     delim_ff[0]    <= csr_wdata;
               qfs_pkg::CSR_DELIM_B:     delim_ff[1]    <= csr_wdata;
               qfs_pkg::CSR_DELIM_C:     delim_ff[2]    <= csr_wdata;
               qfs_pkg::CSR_DELIM_D:     delim_ff[3]    <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      se_ff        <= se_in;
      tail_ff      <= tail_in;
      tail_byte_ff <= tail_byte_in;
      rsp_word_ff  <= rsp_word_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.out_byte   = rsp_word_ff.out_byte;
   assign rsp_if.byte_valid = rsp_word_ff.byte_valid;
   assign rsp_if.field_end  = rsp_word_ff.field_end;
   assign rsp_if.string_end = rsp_word_ff.string_end;
   assign rsp_if.overflow   = rsp_word_ff.overflow;
   assign rsp_if.run_last   = rsp_word_ff.run_last;

endmodule

// File: tb/tb_quoted_field_splitter_core.sv
// Self-checking testbench for quoted_field_splitter_core: directed table, then random strings.
module tb_quoted_field_splitter_core;

   localparam int unsigned WATCHDOG_CYCLES = 1_000_000;
   localparam int unsigned DRAIN_LIMIT     = 4000;
   localparam int unsigned SETTLE_CYCLES   = 4;
   localparam int unsigned LONG_HOLD       = 300;
   localparam int unsigned PHASE_WORDS     = 14;

   typedef enum {ROW_WORD, ROW_CSR} row_kind_type;
   typedef enum {EXP_PRED, EXP_BYTE, EXP_FIELD, EXP_STRING} exp_kind_type;

   typedef struct {
      row_kind_type                      kind;
      logic [qfs_pkg::CSR_INDEX_W-1:0]   index;
      logic [qfs_pkg::BYTE_W-1:0]        data;
      bit                                term;
      exp_kind_type                      exp;
   } dir_row_type;

   typedef struct {
      logic [qfs_pkg::BYTE_W-1:0] data;
      bit                         term;
      exp_kind_type               exp;
   } stim_word_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_we = 1'b0;
   logic [qfs_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [qfs_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   qfs_req_if req_bus ();
   qfs_rsp_if rsp_bus ();

   quoted_field_splitter_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // splitter state as predicted
   qfs_pkg::parse_mode_type          split_mode;
   logic [qfs_pkg::BYTE_W-1:0]       quote_buf [32];
   int unsigned                      quote_fill;
   bit                               quote_trunc;
   logic [qfs_pkg::DELIM_CNT_W-1:0]  sep_count;
   logic [qfs_pkg::BYTE_W-1:0]       sep_regs [qfs_pkg::DELIM_REGS];

   qfs_pkg::rsp_word_type step_words [$];
   qfs_pkg::rsp_word_type pending_rsp [$];
   stim_word_type         word_q [$];
   stim_word_type         offer;

   bit          req_fired = 1'b0;
   bit          quiet = 1'b0;
   bit          long_hold_req = 1'b0;
   int unsigned queued_total = 0;
   int unsigned fired_total = 0;
   int unsigned errors = 0;
   int unsigned results_seen = 0;
   int unsigned fields_closed = 0;
   int unsigned strings_closed = 0;
   int unsigned truncated_fields = 0;
   int unsigned settings_used = 1;
   int unsigned longest_hold = 0;

   dir_row_type directed_rows [30] = '{
      '{ROW_WORD, '0, 8'h00, 1'b1, EXP_STRING},
      '{ROW_WORD, '0, 8'h2C, 1'b0, EXP_FIELD},
      '{ROW_WORD, '0, 8'hFF, 1'b1, EXP_STRING},
      '{ROW_WORD, '0, 8'h61, 1'b0, EXP_BYTE},
      '{ROW_WORD, '0, 8'h00, 1'b0, EXP_BYTE},
      '{ROW_WORD, '0, 8'hFF, 1'b0, EXP_BYTE},
      '{ROW_WORD, '0, 8'h00, 1'b1, EXP_STRING},
      '{ROW_WORD, '0, 8'h22, 1'b0, EXP_PRED},
      '{ROW_WORD, '0, 8'h78, 1'b0, EXP_PRED},
      '{ROW_WORD, '0, 8'h22, 1'b0, EXP_PRED},
      '{ROW_WORD, '0, 8'h22, 1'b0, EXP_PRED},
      '{ROW_WORD, '0, 8'h79, 1'b0, EXP_PRED},
      '{ROW_WORD, '0, 8'h22, 1'b0, EXP_PRED},
      '{ROW_WORD, '0, 8'h2C, 1'b0, EXP_PRED},
      '{ROW_WORD, '0, 8'h22, 1'b0, EXP_PRED},
      '{ROW_WORD, '0, 8'h7A, 1'b0, EXP_PRED},
      '{ROW_WORD, '0, 8'h00, 1'b1, EXP_STRING},
      '{ROW_WORD, '0, 8'h22, 1'b0, EXP_PRED},
      '{ROW_WORD, '0, 8'h22, 1'b0, EXP_PRED},
      '{ROW_WORD, '0, 8'h71, 1'b0, EXP_PRED},
      '{ROW_WORD, '0, 8'h00, 1'b1, EXP_STRING},
      '{ROW_CSR, qfs_pkg::CSR_DELIM_COUNT, 8'd2, 1'b0, EXP_PRED},
      '{ROW_CSR, qfs_pkg::CSR_DELIM_A, qfs_pkg::QUOTE_BYTE, 1'b0, EXP_PRED},
      '{ROW_CSR, qfs_pkg::CSR_DELIM_B, 8'h00, 1'b0, EXP_PRED},
      '{ROW_WORD, '0, 8'h61, 1'b0, EXP_BYTE},
      '{ROW_WORD, '0, 8'h22, 1'b0, EXP_FIELD},
      '{ROW_WORD, '0, 8'h22, 1'b0, EXP_PRED},
      '{ROW_WORD, '0, 8'h00, 1'b1, EXP_STRING},
      '{ROW_WORD, '0, 8'h00, 1'b0, EXP_BYTE},
      '{ROW_WORD, '0, 8'hA5, 1'b1, EXP_STRING}
   };

   function automatic bit is_separator(logic [qfs_pkg::BYTE_W-1:0] b);
      int n;
      n = int'(sep_count);
      if (n > 4) n = 4;
      if (n > int'(qfs_pkg::DELIM_REGS)) n = int'(qfs_pkg::DELIM_REGS);
      for (int i = 0; i < n; i++) begin
         if (sep_regs[i] != 8'h00 && sep_regs[i] == b) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void emit_word(logic [qfs_pkg::BYTE_W-1:0] b, bit valid, bit fe, bit se,
                                     bit ov);
      qfs_pkg::rsp_word_type w;
      w.out_byte   = valid ? b : '0;
      w.byte_valid = valid;
      w.field_end  = fe;
      w.string_end = se;
      w.overflow   = ov;
      w.run_last   = 1'b0;
      step_words.push_back(w);
   endfunction

   function automatic void emit_quoted_field(bit se);
      for (int i = 0; i < quote_fill && i < 32; i++) begin
         emit_word(quote_buf[i], 1'b1, 1'b0, 1'b0, 1'b0);
      end
      emit_word('0, 1'b0, 1'b1, se, quote_trunc);
      quote_fill  = 0;
      quote_trunc = 1'b0;
   endfunction

   function automatic void keep_quoted(logic [qfs_pkg::BYTE_W-1:0] b);
      if (quote_fill < 32) begin
         quote_buf[quote_fill] = b;
         quote_fill++;
      end else begin
         quote_trunc = 1'b1;
      end
   endfunction

   function automatic void open_field(logic [qfs_pkg::BYTE_W-1:0] b);
      if (b == qfs_pkg::QUOTE_BYTE) begin
         quote_fill  = 0;
         quote_trunc = 1'b0;
         split_mode  = qfs_pkg::MODE_QUOTED;
      end else if (is_separator(b)) begin
         emit_word('0, 1'b0, 1'b1, 1'b0, 1'b0);
         split_mode = qfs_pkg::MODE_START;
      end else begin
         emit_word(b, 1'b1, 1'b0, 1'b0, 1'b0);
         split_mode = qfs_pkg::MODE_UNQ;
      end
   endfunction

   function automatic void split_step(logic [qfs_pkg::BYTE_W-1:0] b, bit term);
      qfs_pkg::rsp_word_type w;
      step_words.delete();
      unique case (split_mode)
         qfs_pkg::MODE_START: begin
            if (term) emit_word('0, 1'b0, 1'b1, 1'b1, 1'b0);
            else open_field(b);
         end
         qfs_pkg::MODE_UNQ: begin
            if (term) begin
               emit_word('0, 1'b0, 1'b1, 1'b1, 1'b0);
               split_mode = qfs_pkg::MODE_START;
            end else if (is_separator(b)) begin
               emit_word('0, 1'b0, 1'b1, 1'b0, 1'b0);
               split_mode = qfs_pkg::MODE_START;
            end else begin
               emit_word(b, 1'b1, 1'b0, 1'b0, 1'b0);
            end
         end
         qfs_pkg::MODE_QUOTED: begin
            if (term) begin
               quote_fill  = 0;
               quote_trunc = 1'b0;
               emit_word('0, 1'b0, 1'b1, 1'b1, 1'b0);
               split_mode = qfs_pkg::MODE_START;
            end else if (b == qfs_pkg::QUOTE_BYTE) begin
               split_mode = qfs_pkg::MODE_QSEEN;
            end else begin
               keep_quoted(b);
            end
         end
         default: begin
            if (term) begin
               emit_quoted_field(1'b1);
               split_mode = qfs_pkg::MODE_START;
            end else if (b == qfs_pkg::QUOTE_BYTE) begin
               keep_quoted(b);
               split_mode = qfs_pkg::MODE_QUOTED;
            end else if (is_separator(b)) begin
               emit_quoted_field(1'b0);
               split_mode = qfs_pkg::MODE_START;
            end else begin
               emit_quoted_field(1'b0);
               emit_word(b, 1'b1, 1'b0, 1'b0, 1'b0);
               split_mode = qfs_pkg::MODE_UNQ;
            end
         end
      endcase
      if (step_words.size() > 0) begin
         w = step_words.pop_back();
         w.run_last = 1'b1;
         step_words.push_back(w);
      end
   endfunction

   function automatic qfs_pkg::rsp_word_type typed_word(exp_kind_type kind,
                                                        logic [qfs_pkg::BYTE_W-1:0] b);
      qfs_pkg::rsp_word_type w;
      w = '0;
      w.run_last = 1'b1;
      unique case (kind)
         EXP_BYTE: begin
            w.out_byte   = b;
            w.byte_valid = 1'b1;
         end
         EXP_FIELD:  w.field_end = 1'b1;
         EXP_STRING: begin
            w.field_end  = 1'b1;
            w.string_end = 1'b1;
         end
         default: ;
      endcase
      return w;
   endfunction

   function automatic void check_field(string name, logic [qfs_pkg::BYTE_W-1:0] want,
                                       logic [qfs_pkg::BYTE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endfunction

   function automatic void check_bit(string name, logic want, logic got);
      if (got !== want) begin
         $error("%s: expected %0b, actual %0b", name, want, got);
         errors++;
      end
   endfunction

   function automatic void check_rsp();
      qfs_pkg::rsp_word_type want;
      results_seen++;
      if (pending_rsp.size() == 0) begin
         $error("result word with nothing expected: byte %0h valid %0b fend %0b send %0b",
                rsp_bus.out_byte, rsp_bus.byte_valid, rsp_bus.field_end, rsp_bus.string_end);
         errors++;
      end else begin
         want = pending_rsp.pop_front();
         check_field("out_byte", want.out_byte, rsp_bus.out_byte);
         check_bit("byte_valid", want.byte_valid, rsp_bus.byte_valid);
         check_bit("field_end", want.field_end, rsp_bus.field_end);
         check_bit("string_end", want.string_end, rsp_bus.string_end);
         check_bit("overflow", want.overflow, rsp_bus.overflow);
         check_bit("run_last", want.run_last, rsp_bus.run_last);
         if (want.field_end) fields_closed++;
         if (want.string_end) strings_closed++;
         if (want.overflow) truncated_fields++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) check_rsp();
         req_fired = req_bus.valid && req_bus.ready;
         if (req_fired) begin
            split_step(req_bus.in_byte, req_bus.is_terminator);
            if (offer.exp != EXP_PRED) pending_rsp.push_back(typed_word(offer.exp, offer.data));
            else foreach (step_words[i]) pending_rsp.push_back(step_words[i]);
            fired_total++;
         end
      end
   end

   // sender: hold an offered word until it is taken
   initial begin
      int unsigned gap_left;
      gap_left = 0;
      req_bus.valid         = 1'b0;
      req_bus.in_byte       = '0;
      req_bus.is_terminator = 1'b0;
      offer = '{8'h00, 1'b0, EXP_PRED};
      forever begin
         @(negedge clock);
         if (!(req_bus.valid && !req_fired)) begin
            if (gap_left > 0) begin
               req_bus.valid = 1'b0;
               gap_left--;
            end else if (word_q.size() > 0 && !quiet && $urandom_range(0, 5) == 0) begin
               req_bus.valid = 1'b0;
               gap_left = $urandom_range(1, 16) - 1;
            end else if (word_q.size() > 0) begin
               offer = word_q.pop_front();
               req_bus.in_byte       = offer.data;
               req_bus.is_terminator = offer.term;
               req_bus.valid         = 1'b1;
            end else begin
               req_bus.valid = 1'b0;
            end
         end
      end
   end

   // receiver: random stalls plus one long hold on request
   initial begin
      int unsigned stall_left;
      int unsigned hold_run;
      stall_left = 0;
      hold_run   = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
            hold_run++;
         end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_bus.ready = 1'b0;
            stall_left = LONG_HOLD - 1;
            hold_run = 1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready = 1'b0;
            stall_left = $urandom_range(1, 16) - 1;
            hold_run = 1;
         end else begin
            rsp_bus.ready = 1'b1;
            hold_run = 0;
         end
         if (hold_run > longest_hold) longest_hold = hold_run;
      end
   end

   task automatic queue_word(logic [qfs_pkg::BYTE_W-1:0] data, bit term, exp_kind_type exp);
      stim_word_type w;
      w.data = data;
      w.term = term;
      w.exp  = exp;
      word_q.push_back(w);
      queued_total++;
   endtask

   function automatic logic [qfs_pkg::BYTE_W-1:0] pick_delim();
      int n;
      n = (int'(sep_count) > 4) ? 4 : int'(sep_count);
      if (n == 0) return 8'($urandom_range(0, 255));
      return sep_regs[$urandom_range(0, n - 1)];
   endfunction

   function automatic logic [qfs_pkg::BYTE_W-1:0] plain_byte();
      logic [qfs_pkg::BYTE_W-1:0] b;
      b = 8'($urandom_range(0, 255));
      while (b == qfs_pkg::QUOTE_BYTE || is_separator(b)) b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   function automatic logic [qfs_pkg::BYTE_W-1:0] noise_byte();
      case ($urandom_range(0, 3))
         0: return pick_delim();
         1: return qfs_pkg::QUOTE_BYTE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic queue_plain(int n);
      repeat (n) queue_word(plain_byte(), 1'b0, EXP_PRED);
   endtask

   task automatic queue_quoted_body();
      int len;
      logic [qfs_pkg::BYTE_W-1:0] b;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 5);
      repeat (len) begin
         b = ($urandom_range(0, 7) == 0) ? qfs_pkg::QUOTE_BYTE : 8'($urandom_range(0, 255));
         queue_word(b, 1'b0, EXP_PRED);
         if (b == qfs_pkg::QUOTE_BYTE) queue_word(b, 1'b0, EXP_PRED);
      end
   endtask

   task automatic queue_strings(int unsigned want);
      int unsigned start;
      int nf;
      int f;
      int pick;
      start = queued_total;
      while (queued_total - start < want) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            repeat ($urandom_range(0, 8)) queue_word(noise_byte(), 1'b0, EXP_PRED);
         end else if (pick == 1) begin
            queue_plain($urandom_range(0, 3));
            if ($urandom_range(0, 1)) queue_word(pick_delim(), 1'b0, EXP_PRED);
            queue_word(qfs_pkg::QUOTE_BYTE, 1'b0, EXP_PRED);
            queue_quoted_body();
         end else begin
            nf = $urandom_range(1, 4);
            for (f = 0; f < nf; f++) begin
               if (f > 0) queue_word(pick_delim(), 1'b0, EXP_PRED);
               if ($urandom_range(0, 1)) begin
                  queue_word(qfs_pkg::QUOTE_BYTE, 1'b0, EXP_PRED);
                  queue_quoted_body();
                  queue_word(qfs_pkg::QUOTE_BYTE, 1'b0, EXP_PRED);
                  if ($urandom_range(0, 4) == 0) queue_plain($urandom_range(1, 3));
               end else begin
                  queue_plain($urandom_range(0, 5));
               end
            end
            if ($urandom_range(0, 5) == 0) queue_word(pick_delim(), 1'b0, EXP_PRED);
         end
         queue_word(8'($urandom_range(0, 255)), 1'b1, EXP_PRED);
      end
   endtask

   task automatic wait_drained();
      int unsigned waited;
      waited = 0;
      do @(negedge clock); while (fired_total != queued_total);
      while (pending_rsp.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (pending_rsp.size() != 0) begin
         $error("%0d expected result words never arrived", pending_rsp.size());
         errors++;
         pending_rsp.delete();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(logic [qfs_pkg::CSR_INDEX_W-1:0] index,
                            logic [qfs_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      unique case (index)
         qfs_pkg::CSR_DELIM_COUNT: sep_count   = data[qfs_pkg::DELIM_CNT_W-1:0];
         qfs_pkg::CSR_DELIM_A:     sep_regs[0] = data;
         qfs_pkg::CSR_DELIM_B:     sep_regs[1] = data;
         qfs_pkg::CSR_DELIM_C:     sep_regs[2] = data;
         qfs_pkg::CSR_DELIM_D:     sep_regs[3] = data;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic run_phase(logic [qfs_pkg::DELIM_CNT_W-1:0] count,
                            logic [qfs_pkg::BYTE_W-1:0] a, logic [qfs_pkg::BYTE_W-1:0] b,
                            logic [qfs_pkg::BYTE_W-1:0] c, logic [qfs_pkg::BYTE_W-1:0] d,
                            bit hold);
      wait_drained();
      write_csr(qfs_pkg::CSR_DELIM_COUNT, qfs_pkg::CSR_DATA_W'(count));
      write_csr(qfs_pkg::CSR_DELIM_A, a);
      write_csr(qfs_pkg::CSR_DELIM_B, b);
      write_csr(qfs_pkg::CSR_DELIM_C, c);
      write_csr(qfs_pkg::CSR_DELIM_D, d);
      settings_used++;
      queue_strings(PHASE_WORDS);
      if (hold) long_hold_req = 1'b1;
   endtask

   initial begin
      #(WATCHDOG_CYCLES * 10);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      split_mode  = qfs_pkg::MODE_START;
      quote_fill  = 0;
      quote_trunc = 1'b0;
      sep_count   = qfs_pkg::DELIM_COUNT_RESET;
      sep_regs[0] = qfs_pkg::DELIM_A_RESET;
      sep_regs[1] = qfs_pkg::DELIM_B_RESET;
      sep_regs[2] = qfs_pkg::DELIM_C_RESET;
      sep_regs[3] = qfs_pkg::DELIM_D_RESET;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_drained();
            write_csr(directed_rows[i].index, directed_rows[i].data);
         end else begin
            queue_word(directed_rows[i].data, directed_rows[i].term, directed_rows[i].exp);
         end
      end

      run_phase(3'd4, qfs_pkg::DELIM_A_RESET, qfs_pkg::DELIM_B_RESET, qfs_pkg::DELIM_C_RESET,
                qfs_pkg::DELIM_D_RESET, 1'b0);
      run_phase(3'd0, qfs_pkg::DELIM_A_RESET, qfs_pkg::DELIM_B_RESET, qfs_pkg::DELIM_C_RESET,
                qfs_pkg::DELIM_D_RESET, 1'b0);
      run_phase(3'd7, 8'hFF, 8'h00, qfs_pkg::QUOTE_BYTE, 8'h01, 1'b0);
      run_phase(3'd3, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 1'b0);
      run_phase(3'd2, qfs_pkg::QUOTE_BYTE, 8'h2C, 8'h0A, 8'h7C, 1'b1);
      run_phase(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)), 1'b0);
      wait_drained();
      quiet = 1'b1;
      run_phase(qfs_pkg::DELIM_COUNT_RESET, qfs_pkg::DELIM_A_RESET, qfs_pkg::DELIM_B_RESET,
                qfs_pkg::DELIM_C_RESET, qfs_pkg::DELIM_D_RESET, 1'b0);
      wait_drained();

      $display("Sent %0d input words under %0d delimiter setups, checked %0d result words.",
               queued_total, settings_used, results_seen);
      $display("Fields %0d, strings %0d, truncated quoted fields %0d, longest hold %0d.",
               fields_closed, strings_closed, truncated_fields, longest_hold);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/qfs_pkg.sv
src/qfs_req_if.sv
src/qfs_rsp_if.sv
src/qfs_store.sv
src/quoted_field_splitter_core.sv
tb/tb_quoted_field_splitter_core.sv
